>>> rtl/rrq_pkg.sv
// Shared types, constants and codes for the round-robin run queue.
package rrq_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int TASK_W      = $clog2(MAX_TASKS);
    localparam int CNT_W       = $clog2(MAX_TASKS + 1);
    localparam int KIND_W      = 3;
    localparam int SLICE_W     = 16;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd100;

    // Event codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_JOIN    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEQUEUE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_YIELD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;

    // Queue operation applied by the cell chain
    typedef enum logic [1:0] {
        QOP_NONE,
        QOP_PUSH,
        QOP_REMOVE,
        QOP_ROTATE
    } qop_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SHIFT,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TASK_W-1:0] task_id;
    } in_item_t;

    typedef struct packed {
        logic [TASK_W-1:0] next_task;
        logic              next_valid;
        logic [CNT_W-1:0]  queued_count;
        logic              resched;
        logic              status;
    } out_item_t;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        qop_t              op;
        logic [TASK_W-1:0] task_id;
        logic [CNT_W-1:0]  count;
    } cell_ctrl_t;

endpackage

>>> rtl/round_robin_run_queue.sv
// Top level of the round-robin run queue with per-task time slices.
//
// Usage:
//   Input channel: drive item (kind, task_id) and raise start; the transaction
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver must take it then, it cannot hold results off.
//   Configuration: cfg_we with cfg_wdata writes the slice length; write only
//   while the block is idle.
// Sequencing:
//   The sequencer walks evaluate, queue update and report; done and the result
//   are registered from the report state, and busy drops in the cycle done is
//   shown. No new transaction is taken before busy drops.
//   Queue removal and rotation are done by a row of slot cells that each
//   compare their task number and shift from their neighbour during the queue update.
// Reset:
//   Queue empty, every slice counter zero, slice length 100, no result shown.
module round_robin_run_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rrq_pkg::in_item_t           item,
    output logic                        done,
    output rrq_pkg::out_item_t          result,
    input  logic                        cfg_we,
    input  logic [rrq_pkg::SLICE_W-1:0] cfg_wdata
);

    localparam int N = rrq_pkg::MAX_TASKS;

    logic eval_en;
    logic shift_en;
    logic report_en;

    logic [rrq_pkg::SLICE_W-1:0] slice_ticks_reg;
    logic [rrq_pkg::SLICE_W-1:0] slice_left_reg [N];
    logic [N-1:0]                in_queue_reg;
    logic [rrq_pkg::CNT_W-1:0]   count_reg;

    rrq_pkg::in_item_t           ev_reg;
    rrq_pkg::qop_t               op_reg;
    rrq_pkg::qop_t               op_next;
    logic                        status_reg;
    logic                        status_next;
    logic                        resched_reg;
    logic                        resched_next;
    logic                        slice_we;
    logic [rrq_pkg::SLICE_W-1:0] slice_wval;

    rrq_pkg::out_item_t          result_reg;
    logic                        done_reg;

    logic [rrq_pkg::SLICE_W-1:0] slice_cur;
    logic [rrq_pkg::SLICE_W-1:0] slice_dec;
    logic                        expired;
    logic                        present;

    rrq_pkg::cell_ctrl_t         ctrl;
    logic [rrq_pkg::TASK_W-1:0]  slot_task [N];
    logic [N:0]                  hit;

    rrq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .eval_en   (eval_en),
        .shift_en  (shift_en),
        .report_en (report_en)
    );

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            ev_reg <= item;
    end

    // Slice length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slice_ticks_reg <= rrq_pkg::SLICE_RESET;
        else if (cfg_we)
            slice_ticks_reg <= cfg_wdata;
    end

    // Slice counter of the named task; a counter at zero expires at once
    assign slice_cur = slice_left_reg[ev_reg.task_id];
    assign slice_dec = slice_cur - rrq_pkg::SLICE_W'(1);
    assign expired   = (slice_cur == '0) || (slice_dec == '0);
    assign present   = in_queue_reg[ev_reg.task_id];

    // Event decode: slice update, queue operation and status
    always_comb
    begin
        op_next      = rrq_pkg::QOP_NONE;
        status_next  = 1'b0;
        resched_next = 1'b0;
        slice_we     = 1'b0;
        slice_wval   = slice_ticks_reg;
        unique case (ev_reg.kind)
            rrq_pkg::KIND_JOIN:
            begin
                slice_we = 1'b1;
            end
            rrq_pkg::KIND_ENQUEUE:
            begin
                if (present)
                    status_next = 1'b1;
                else
                    op_next = rrq_pkg::QOP_PUSH;
            end
            rrq_pkg::KIND_DEQUEUE:
            begin
                if (!present)
                    status_next = 1'b1;
                else
                    op_next = rrq_pkg::QOP_REMOVE;
            end
            rrq_pkg::KIND_YIELD:
            begin
                if (!present)
                    status_next = 1'b1;
                else
                    op_next = rrq_pkg::QOP_ROTATE;
            end
            rrq_pkg::KIND_TICK:
            begin
                slice_we   = 1'b1;
                slice_wval = expired ? slice_ticks_reg : slice_dec;
                if (expired && present && (count_reg > rrq_pkg::CNT_W'(1)))
                begin
                    op_next      = rrq_pkg::QOP_ROTATE;
                    resched_next = 1'b1;
                end
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= rrq_pkg::QOP_NONE;
        else if (eval_en)
            op_reg <= op_next;
    end

    always_ff @(posedge clk)
    begin
        if (eval_en)
        begin
            status_reg  <= status_next;
            resched_reg <= resched_next;
        end
    end

    // Per-task slice counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                slice_left_reg[i] <= '0;
        end
        else if (eval_en && slice_we)
        begin
            slice_left_reg[ev_reg.task_id] <= slice_wval;
        end
    end

    // Queued bits and count, updated with the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_queue_reg <= '0;
            count_reg    <= '0;
        end
        else if (shift_en)
        begin
            unique case (op_reg)
                rrq_pkg::QOP_PUSH:
                begin
                    in_queue_reg[ev_reg.task_id] <= 1'b1;
                    count_reg <= count_reg + rrq_pkg::CNT_W'(1);
                end
                rrq_pkg::QOP_REMOVE:
                begin
                    in_queue_reg[ev_reg.task_id] <= 1'b0;
                    count_reg <= count_reg - rrq_pkg::CNT_W'(1);
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // Chain of queue slots, head at cell 0
    always_comb
    begin
        ctrl.op      = shift_en ? op_reg : rrq_pkg::QOP_NONE;
        ctrl.task_id = ev_reg.task_id;
        ctrl.count   = count_reg;
    end

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        rrq_cell u_cell (
            .clk       (clk),
            .cell_idx  (rrq_pkg::TASK_W'(i)),
            .ctrl      (ctrl),
            .nbr_task  (slot_task[(i + 1 < N) ? i + 1 : i]),
            .hit_in    (hit[i]),
            .hit_out   (hit[i+1]),
            .slot_task (slot_task[i])
        );
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (report_en)
        begin
            result_reg.next_valid   <= (count_reg != '0);
            result_reg.next_task    <= (count_reg != '0) ? slot_task[0] : '0;
            result_reg.queued_count <= count_reg;
            result_reg.resched      <= resched_reg;
            result_reg.status       <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= report_en;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/rrq_cell.sv
// One queue slot of the run queue chain: holds a task number, shifts from its neighbour.
module rrq_cell (
    input  logic                       clk,
    input  logic [rrq_pkg::TASK_W-1:0] cell_idx,
    input  rrq_pkg::cell_ctrl_t        ctrl,
    input  logic [rrq_pkg::TASK_W-1:0] nbr_task,
    input  logic                       hit_in,
    output logic                       hit_out,
    output logic [rrq_pkg::TASK_W-1:0] slot_task
);

    logic [rrq_pkg::TASK_W-1:0] task_reg;
    logic [rrq_pkg::TASK_W-1:0] task_next;
    logic [rrq_pkg::CNT_W-1:0]  pos;
    logic                       occupied;
    logic                       match;
    logic                       at_tail;
    logic                       at_free;

    assign pos       = rrq_pkg::CNT_W'(cell_idx);
    assign occupied  = pos < ctrl.count;
    assign match     = occupied && (task_reg == ctrl.task_id);
    assign hit_out   = hit_in | match;
    assign at_tail   = (pos == ctrl.count - rrq_pkg::CNT_W'(1));
    assign at_free   = (pos == ctrl.count);
    assign slot_task = task_reg;

    // Slot update: close the gap behind the removed or rotated task, append at the tail
    always_comb
    begin
        task_next = task_reg;
        unique case (ctrl.op)
            rrq_pkg::QOP_PUSH:
            begin
                if (at_free)
                    task_next = ctrl.task_id;
            end
            rrq_pkg::QOP_REMOVE:
            begin
                if (hit_out)
                    task_next = nbr_task;
            end
            rrq_pkg::QOP_ROTATE:
            begin
                if (at_tail)
                    task_next = ctrl.task_id;
                else if (hit_out)
                    task_next = nbr_task;
            end
            default:
            begin
                task_next = task_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
    end

endmodule

>>> rtl/rrq_seq.sv
// Event sequencer of the run queue: state register with next-state and output decode.
module rrq_seq (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic eval_en,
    output logic shift_en,
    output logic report_en
);

    rrq_pkg::state_t state_reg;
    rrq_pkg::state_t state_next;

    // Next state
    always_comb
    begin
        unique case (state_reg)
            rrq_pkg::ST_IDLE:   state_next = start ? rrq_pkg::ST_EVAL : rrq_pkg::ST_IDLE;
            rrq_pkg::ST_EVAL:   state_next = rrq_pkg::ST_SHIFT;
            rrq_pkg::ST_SHIFT:  state_next = rrq_pkg::ST_REPORT;
            rrq_pkg::ST_REPORT: state_next = rrq_pkg::ST_IDLE;
            default:            state_next = rrq_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy      = 1'b1;
        eval_en   = 1'b0;
        shift_en  = 1'b0;
        report_en = 1'b0;
        unique case (state_reg)
            rrq_pkg::ST_IDLE:   busy      = 1'b0;
            rrq_pkg::ST_EVAL:   eval_en   = 1'b1;
            rrq_pkg::ST_SHIFT:  shift_en  = 1'b1;
            rrq_pkg::ST_REPORT: report_en = 1'b1;
            default:            busy      = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rrq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/rrq_checker.sv
// Port-level checks for the run queue, bound to the top level.
module rrq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input rrq_pkg::out_item_t result
);

    // An accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transaction");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result shown without work in progress");

    // Results are never shown in two consecutive cycles
    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // Head valid agrees with count
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.next_valid == (result.queued_count != '0)))
        else $error("next_valid disagrees with queued_count");

    // Count never exceeds the number of tasks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.queued_count <= rrq_pkg::CNT_W'(rrq_pkg::MAX_TASKS)))
        else $error("queued_count out of range");

endmodule

bind round_robin_run_queue rrq_checker u_rrq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
